FILE: design/wind_sensor_message_decoder_defines.svh
// Assertion macros shared by the wind sensor message decoder modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef WIND_SENSOR_MESSAGE_DECODER_DEFINES_SVH
`define WIND_SENSOR_MESSAGE_DECODER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define WSMD_ASSERT_NOW(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define WSMD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WSMD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/wsmd_pkg.sv
// Shared types, constants and helpers for the wind sensor message decoder.
// No dependencies.
package wsmd_pkg;

  localparam int unsigned MSG_BYTES = 10;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned SUM_W     = 9;
  localparam int unsigned VAL_W     = 11;

  // Known sensor type pairs (byte zero, byte one).
  localparam logic [7:0] TYPE_A0 = 8'h3A;
  localparam logic [7:0] TYPE_A1 = 8'h0D;
  localparam logic [7:0] TYPE_B0 = 8'h19;
  localparam logic [7:0] TYPE_B1 = 8'h84;
  localparam logic [7:0] TYPE_C0 = 8'h19;
  localparam logic [7:0] TYPE_C1 = 8'h94;
  localparam logic [7:0] TYPE_D0 = 8'h1A;
  localparam logic [7:0] TYPE_D1 = 8'h89;

  localparam logic [SUM_W-1:0] CHECK_OFFSET = SUM_W'(10);
  localparam logic [3:0]       BATT_MIN     = 4'd4;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_BAD_SUM  = 2'd2
  } status_t;

  // Completed message as seen by the decode stage.
  typedef struct packed {
    logic             done;
    logic [7:0]       type0;
    logic [7:0]       type1;
    logic [7:0]       b4;
    logic [7:0]       b5;
    logic [7:0]       b6;
    logic [7:0]       b7;
    logic [7:0]       b8;
    logic [7:0]       check;
    logic [SUM_W-1:0] sum;
  } msg_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] direction;
    logic [VAL_W-1:0] gust;
    logic [VAL_W-1:0] average;
    logic             battery;
    logic [7:0]       sensor;
  } result_t;

  // Three nibbles weighted 100/10/1; max 1665 fits eleven bits.
  function automatic logic [VAL_W-1:0] digits3(input logic [3:0] h, input logic [3:0] t,
                                               input logic [3:0] o);
    digits3 = VAL_W'(h) * VAL_W'(100) + VAL_W'(t) * VAL_W'(10) + VAL_W'(o);
  endfunction

endpackage

FILE: design/wind_sensor_message_decoder.sv
// Wind sensor message decoder: ten bytes in, one decoded result out.
// The tenth byte passes through the input register and then the result register, which
// raises m_tvalid; an untaken waiting result can hold the byte back on the way.
// Throughput: one byte per cycle; a waiting result stalls input only when not taken.
// Reset clears the input and result valids, byte count and nibble sum;
// the byte store is not reset and is always written before it is read.
module wind_sensor_message_decoder import wsmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tuser,   // [0] first_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [1:0] status, [12:2] direction, [23:13] gust_tenths,
                                 // [34:24] average_tenths, [35] battery_good,
                                 // [43:36] sensor_byte, [47:44] zero
);

  logic    advance;
  msg_t    msg;
  result_t result;

  assign advance = !m_tvalid || m_tready;

  wsmd_collect u_collect (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .msg      (msg)
  );

  wsmd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .msg     (msg),
    .m_valid (m_tvalid),
    .result  (result)
  );

  assign m_tdata = {4'b0000, result.sensor, result.battery, result.average,
                    result.gust, result.direction, result.status};

endmodule

FILE: design/wsmd_collect.sv
// Input register, byte counter, nibble sum and message byte store.
// Depends on wsmd_pkg and the assertion macro header.
`include "wind_sensor_message_decoder_defines.svh"

module wsmd_collect import wsmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  input  logic       s_tuser,   // [0] first_byte
  input  logic       advance,
  output msg_t       msg
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_first;
  logic [CNT_W-1:0] byte_count;
  logic [SUM_W-1:0] nibble_sum;
  logic [7:0]       store [0:MSG_BYTES-2];

  logic [CNT_W-1:0] cnt_eff;
  logic [SUM_W-1:0] sum_eff;
  logic [SUM_W-1:0] sum_add;
  logic             take;
  logic             in_msg;

  assign s_tready = !in_valid || advance;

  always_comb begin
    cnt_eff = in_first ? '0 : byte_count;
    sum_eff = in_first ? '0 : nibble_sum;
    sum_add = sum_eff + SUM_W'(in_byte[7:4]) + SUM_W'(in_byte[3:0]);
    take    = in_valid && advance && (cnt_eff < CNT_W'(MSG_BYTES));
    // byte nine is the check byte: not summed and not stored
    in_msg  = cnt_eff < CNT_W'(MSG_BYTES - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      byte_count <= '0;
      nibble_sum <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (take) begin
        byte_count <= cnt_eff + CNT_W'(1);
        if (in_msg) begin
          nibble_sum <= sum_add;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
    end
    if (take && in_msg) begin
      store[cnt_eff] <= in_byte;
    end
  end

  always_comb begin
    msg.done  = take && (cnt_eff == CNT_W'(MSG_BYTES - 1));
    msg.type0 = store[0];
    msg.type1 = store[1];
    msg.b4    = store[4];
    msg.b5    = store[5];
    msg.b6    = store[6];
    msg.b7    = store[7];
    msg.b8    = store[8];
    msg.check = in_byte;
    msg.sum   = sum_eff;
  end

  `WSMD_ASSERT_NOW(a_count_range, byte_count <= CNT_W'(MSG_BYTES), "byte count past message length")
  `WSMD_ASSERT_NXT(a_count_full, msg.done, byte_count == CNT_W'(MSG_BYTES), "count not full after last byte")
  `WSMD_ASSERT_NXT(a_stall_holds, in_valid && !advance, in_valid && $stable(in_byte), "stalled byte lost")

endmodule

FILE: design/wsmd_decode.sv
// Type and checksum check, field assembly and result register.
// Depends on wsmd_pkg and the assertion macro header.
`include "wind_sensor_message_decoder_defines.svh"

module wsmd_decode import wsmd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  msg_t    msg,
  output logic    m_valid,
  output result_t result
);

  logic    type_ok;
  logic    sum_ok;
  result_t res_next;
  logic    res_empty;

  always_comb begin
    type_ok = (msg.type0 == TYPE_A0 && msg.type1 == TYPE_A1) ||
              (msg.type0 == TYPE_B0 && msg.type1 == TYPE_B1) ||
              (msg.type0 == TYPE_C0 && msg.type1 == TYPE_C1) ||
              (msg.type0 == TYPE_D0 && msg.type1 == TYPE_D1);
    // sum - 10 == check, written without going negative
    sum_ok  = msg.sum == (SUM_W'(msg.check) + CHECK_OFFSET);

    res_next = '0;
    if (!type_ok) begin
      res_next.status = ST_BAD_TYPE;
    end else if (!sum_ok) begin
      res_next.status = ST_BAD_SUM;
    end else begin
      res_next.status    = ST_GOOD;
      res_next.direction = digits3(msg.b5[7:4], msg.b5[3:0], msg.b4[7:4]);
      res_next.gust      = digits3(msg.b7[3:0], msg.b6[7:4], msg.b6[3:0]);
      res_next.average   = digits3(msg.b8[7:4], msg.b8[3:0], msg.b7[7:4]);
      res_next.battery   = msg.b4[3:0] >= BATT_MIN;
      res_next.sensor    = msg.b4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= msg.done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && msg.done) begin
      result <= res_next;
    end
  end

  assign res_empty = result.direction == '0 && result.gust == '0 &&
                     result.average == '0 && !result.battery && result.sensor == '0;

  `WSMD_ASSERT_IMP(a_bad_zeroed, m_valid && result.status != ST_GOOD, res_empty, "bad message carries data")
  `WSMD_ASSERT_NXT(a_result_follows, advance && msg.done, m_valid, "completed message gave no result")
  `WSMD_ASSERT_NXT(a_result_holds, m_valid && !advance, m_valid && $stable(result), "stalled result lost")

endmodule

FILE: sim/tb_wind_sensor_message_decoder.sv
// Testbench for wind_sensor_message_decoder: streams ten-byte wind messages in,
// predicts each decoded result and checks every output transfer field by field.
// Depends on wsmd_pkg and the decoder RTL.
module tb_wind_sensor_message_decoder import wsmd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] frame_t [MSG_BYTES];

  class wind_scoreboard;
    logic [7:0]  msg_bytes [MSG_BYTES];
    int unsigned bytes_seen;
    logic [8:0]  digit_sum;
    result_t     expected_q [$];
    int          errors;

    function new();
      bytes_seen = 0;
      digit_sum  = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [VAL_W-1:0] weigh(logic [3:0] h, logic [3:0] t, logic [3:0] o);
      return VAL_W'(h * 100 + t * 10 + o);
    endfunction

    function bit type_ok(logic [7:0] t0, logic [7:0] t1);
      return (t0 == TYPE_A0 && t1 == TYPE_A1) || (t0 == TYPE_B0 && t1 == TYPE_B1) ||
             (t0 == TYPE_C0 && t1 == TYPE_C1) || (t0 == TYPE_D0 && t1 == TYPE_D1);
    endfunction

    // Returns 1 when the byte is taken into a message, 0 when it is ignored.
    function bit note_byte(logic [7:0] value, logic first);
      result_t r;
      if (first) begin
        bytes_seen = 0;
        digit_sum  = '0;
      end
      if (bytes_seen >= MSG_BYTES) return 0;
      msg_bytes[bytes_seen] = value;
      if (bytes_seen < MSG_BYTES - 1)
        digit_sum = digit_sum + 9'(value[7:4]) + 9'(value[3:0]);
      bytes_seen++;
      if (bytes_seen != MSG_BYTES) return 1;
      r = '0;
      if (!type_ok(msg_bytes[0], msg_bytes[1]))
        r.status = ST_BAD_TYPE;
      else if (digit_sum < 10 || digit_sum - 9'd10 != {1'b0, msg_bytes[9]})
        r.status = ST_BAD_SUM;
      else
        r.status = ST_GOOD;
      if (r.status == ST_GOOD) begin
        r.direction = weigh(msg_bytes[5][7:4], msg_bytes[5][3:0], msg_bytes[4][7:4]);
        r.gust      = weigh(msg_bytes[7][3:0], msg_bytes[6][7:4], msg_bytes[6][3:0]);
        r.average   = weigh(msg_bytes[8][7:4], msg_bytes[8][3:0], msg_bytes[7][7:4]);
        r.battery   = (msg_bytes[4][3:0] >= BATT_MIN);
        r.sensor    = msg_bytes[4];
      end
      expected_q.push_back(r);
      return 1;
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [47:0] data);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none actual %h", $time, data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("status", want.status, data[1:0]);
      compare("direction", want.direction, data[12:2]);
      compare("gust_tenths", want.gust, data[23:13]);
      compare("average_tenths", want.average, data[34:24]);
      compare("battery_good", want.battery, data[35]);
      compare("sensor_byte", want.sensor, data[43:36]);
      compare("pad bits", 0, data[47:44]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  wind_sensor_message_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  wind_scoreboard book = new();
  bit             no_idle = 1'b0;
  int             stall_left = 0;
  int             bytes_taken = 0;

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls; none start while no_idle is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!rst && !no_idle && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_result(m_tdata);
  end

  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] value, input logic first);
    int gap;
    gap = (no_idle || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    if (book.note_byte(value, first)) bytes_taken++;
    @(negedge clk);
  endtask

  task automatic send_message(input frame_t m, input int len, input bit first);
    for (int i = 0; i < len; i++) send_byte(m[i], first && i == 0);
  endtask

  // Entered at a falling edge, left at a later one.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (book.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] good_check(input frame_t m);
    int s;
    s = 0;
    for (int i = 0; i < MSG_BYTES - 1; i++) s += m[i][7:4] + m[i][3:0];
    return 8'(s - 10);
  endfunction

  initial begin
    frame_t m;
    int     s, r, len;
    bit     paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // No first_byte after reset; known type, every digit at its maximum.
    m = '{TYPE_A0, TYPE_A1, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    m[9] = good_check(m);
    send_message(m, MSG_BYTES, 1'b0);
    send_byte(8'h55, 1'b0);                  // past the tenth byte: ignored
    m = '{TYPE_B0, TYPE_B1, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_message(m, 3, 1'b1);                // dropped by the restart below
    m = '{default: 8'h00};                   // unknown type and sum below ten
    send_message(m, MSG_BYTES, 1'b1);
    drain();
    @(negedge clk);

    while (bytes_taken < 850) begin
      no_idle = ($urandom_range(0, 9) == 0);
      if (!paused && bytes_taken > 400) begin
        drain();
        paused = 1'b1;
      end
      r = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 20) begin
        m[0] = 8'($urandom_range(0, 255));
        m[1] = 8'($urandom_range(0, 255));
      end else begin
        m[0] = (r == 0) ? TYPE_A0 : (r == 1) ? TYPE_B0 : (r == 2) ? TYPE_C0 : TYPE_D0;
        m[1] = (r == 0) ? TYPE_A1 : (r == 1) ? TYPE_B1 : (r == 2) ? TYPE_C1 : TYPE_D1;
      end
      for (int i = 2; i < MSG_BYTES; i++) m[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 4; i < MSG_BYTES - 1; i++)
          m[i] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      s = 0;
      for (int i = 0; i < MSG_BYTES - 1; i++) s += m[i][7:4] + m[i][3:0];
      if ($urandom_range(0, 99) < 80 && s >= 10 && s - 10 <= 255) m[9] = good_check(m);
      len = ($urandom_range(0, 99) < 8) ? $urandom_range(1, MSG_BYTES - 1) : MSG_BYTES;
      send_message(m, len, $urandom_range(0, 99) < 92);
      if ($urandom_range(0, 99) < 5) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    no_idle = 1'b0;
    drain();
    repeat (10) @(negedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb_wind_sensor_message_decoder passed");
    end else begin
      $display("tb_wind_sensor_message_decoder failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("tb_wind_sensor_message_decoder failed");
    $finish;
  end

endmodule
